// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and constants for the buddy page allocator.
// Holds request and status codes, the sequencer state and command enums
// and the status struct passed from the datapath to the controller.
package bpa_pkg;

  // Fixed field widths of the transaction ports
  localparam int CNT_W  = 14;
  localparam int ADDR_W = 24;
  localparam int STS_W  = 2;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STS_W-1:0] RES_OK      = 2'd0;
  localparam logic [STS_W-1:0] RES_NOSPACE = 2'd1;
  localparam logic [STS_W-1:0] RES_ILLEGAL = 2'd2;
  localparam logic [STS_W-1:0] RES_DOUBLE  = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_UL_RD,
    ST_UL_WR,
    ST_SPLIT,
    ST_PUSH0,
    ST_PUSH1,
    ST_PUSH2,
    ST_F_CHK,
    ST_F_TRY,
    ST_F_BCHK,
    ST_F_HI,
    ST_F_LO,
    ST_RESULT
  } bpa_state_t;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_UL_RD,
    OP_UL_WR,
    OP_SPLIT,
    OP_PUSH0,
    OP_PUSH1,
    OP_PUSH2,
    OP_F_CHK,
    OP_F_TRY,
    OP_F_BCHK,
    OP_F_HI,
    OP_F_LO,
    OP_RESULT
  } bpa_op_t;

  // Status flags from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_free;
    logic dec_fail;
    logic head_free;
    logic split_more;
    logic split_valid;
    logic try_ok;
    logic merge_ok;
    logic push_empty;
    logic out_busy;
  } bpa_sts_t;

endpackage

// ===== hw/rtl/bpa_ctrl.sv =====
// Sequencer of the buddy page allocator.
// Steps through decode, unlink, split, merge and list push; depends on bpa_pkg.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_op_t  op
);
  import bpa_pkg::*;

  bpa_state_t state_r;
  bpa_state_t state_nxt;
  bpa_state_t ret_st;

  // Return point after a list push
  assign ret_st = sts.req_free ? ST_RESULT : ST_SPLIT;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (sts.dec_fail) state_nxt = ST_RESULT;
        else if (sts.req_free) state_nxt = ST_F_CHK;
        else state_nxt = ST_UL_RD;
      end
      ST_UL_RD:  state_nxt = ST_UL_WR;
      ST_UL_WR:  state_nxt = sts.req_free ? ST_F_HI : ST_SPLIT;
      ST_SPLIT: begin
        if (!sts.split_more) state_nxt = ST_RESULT;
        else if (sts.split_valid) state_nxt = ST_PUSH0;
        else state_nxt = ST_SPLIT;
      end
      ST_PUSH0:  state_nxt = sts.push_empty ? ret_st : ST_PUSH1;
      ST_PUSH1:  state_nxt = ST_PUSH2;
      ST_PUSH2:  state_nxt = ret_st;
      ST_F_CHK:  state_nxt = sts.head_free ? ST_RESULT : ST_F_TRY;
      ST_F_TRY:  state_nxt = sts.try_ok ? ST_F_BCHK : ST_PUSH0;
      ST_F_BCHK: state_nxt = sts.merge_ok ? ST_UL_RD : ST_PUSH0;
      ST_F_HI:   state_nxt = ST_F_LO;
      ST_F_LO:   state_nxt = ST_F_TRY;
      ST_RESULT: if (!sts.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Command decode
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR:  op = OP_CLEAR;
      ST_IDLE:   op = in_valid ? OP_LOAD : OP_NONE;
      ST_DECODE: op = OP_DECODE;
      ST_UL_RD:  op = OP_UL_RD;
      ST_UL_WR:  op = OP_UL_WR;
      ST_SPLIT:  op = OP_SPLIT;
      ST_PUSH0:  op = OP_PUSH0;
      ST_PUSH1:  op = OP_PUSH1;
      ST_PUSH2:  op = OP_PUSH2;
      ST_F_CHK:  op = OP_F_CHK;
      ST_F_TRY:  op = OP_F_TRY;
      ST_F_BCHK: op = OP_F_BCHK;
      ST_F_HI:   op = OP_F_HI;
      ST_F_LO:   op = OP_F_LO;
      ST_RESULT: op = OP_RESULT;
      default:   op = OP_NONE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/bpa_dp.sv =====
// Datapath of the buddy page allocator: page info and link memories,
// free list heads, working registers and the result register; uses bpa_pkg.
module bpa_dp #(
  parameter int NUM_PAGES  = 4096,
  parameter int TOP_ORDER  = 12,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpa_pkg::bpa_op_t            op,
  output bpa_pkg::bpa_sts_t           sts,
  input  logic                        in_req_type,
  input  logic [bpa_pkg::CNT_W-1:0]   in_req_pages,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_byte_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bpa_pkg::STS_W-1:0]   out_status,
  output logic [bpa_pkg::ADDR_W-1:0]  out_block_addr
);
  import bpa_pkg::*;

  localparam int PW   = $clog2(NUM_PAGES);
  localparam int OW   = $clog2(TOP_ORDER + 1);
  localparam int NL   = TOP_ORDER + 1;
  localparam int IW   = OW + 1;
  localparam int PS   = $clog2(PAGE_BYTES);
  localparam int BS   = 1 << TOP_ORDER;
  localparam int KTOP = NUM_PAGES >> TOP_ORDER;
  localparam int TOPB = KTOP << TOP_ORDER;
  localparam int REM  = NUM_PAGES - TOPB;

  // Memories: info holds busy flag over order
  logic [IW-1:0] info_mem [NUM_PAGES];
  logic [PW-1:0] next_mem [NUM_PAGES];
  logic [PW-1:0] prev_mem [NUM_PAGES];

  logic          info_we;
  logic [PW-1:0] info_wa, info_ra;
  logic [IW-1:0] info_wd, info_q;
  logic          next_we, prev_we;
  logic [PW-1:0] next_wa, next_wd, prev_wa, prev_wd, link_ra, next_q, prev_q;

  // Working registers
  logic               req_free_r, req_free_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PW-1:0]      pg_r, pg_nxt, u_r, u_nxt, x_r, x_nxt, h_r, h_nxt, t_r, t_nxt;
  logic [PW-1:0]      clr_r, clr_nxt;
  logic [OW-1:0]      ord_r, ord_nxt, want_r, want_nxt, pord_r, pord_nxt;
  logic [STS_W-1:0]   res_st_r, res_st_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [PW-1:0]      head_r [NL];
  logic [PW-1:0]      head_nxt [NL];
  logic [NL-1:0]      ne_r, ne_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]   out_st_r, out_st_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;

  // Decode helpers
  int            want_i, found_i, pi;
  logic          found_ok, alloc_fail, addr_bad;
  logic [31:0]   fidx;
  logic [PW-1:0] fpg;
  logic [OW-1:0] sord;
  logic [PW-1:0] sbud, fbud, lo_pg, hi_pg;
  logic          sbud_ok, fbud_ok;
  logic          i_head;
  logic [OW-1:0] i_ord;
  logic [PW-1:0] i_next, i_prev;

  // Allocate: order wanted and first non-empty list at or above it
  always_comb begin
    logic [CNT_W-1:0] nm1;
    nm1 = cnt_r - CNT_W'(1);
    want_i = 0;
    if (cnt_r > CNT_W'(1)) begin
      for (int i = 0; i < CNT_W; i++) begin
        if (nm1[i]) want_i = i + 1;
      end
    end
    found_i  = 0;
    found_ok = 1'b0;
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (o >= want_i && ne_r[o]) begin
        found_i  = o;
        found_ok = 1'b1;
      end
    end
    alloc_fail = (want_i > TOP_ORDER) || !found_ok;
  end

  // Free: page index and range check
  assign fidx     = 32'(addr_r) >> PS;
  assign fpg      = fidx[PW-1:0];
  assign addr_bad = (fidx >= 32'(NUM_PAGES));

  // Buddy of the split half and of the merge candidate
  assign sord    = ord_r - OW'(1);
  assign sbud    = pg_r ^ (PW'(1) << sord);
  assign sbud_ok = (int'(sord) < PW) && (int'(sbud) < NUM_PAGES);
  assign fbud    = pg_r ^ (PW'(1) << ord_r);
  assign fbud_ok = (int'(ord_r) < TOP_ORDER) && (int'(ord_r) < PW)
                   && (int'(fbud) < NUM_PAGES);
  assign lo_pg   = (u_r < pg_r) ? u_r : pg_r;
  assign hi_pg   = (u_r < pg_r) ? pg_r : u_r;

  // Initial tiling of one page for the clearing pass
  always_comb begin
    pi     = int'(clr_r);
    i_head = 1'b0;
    i_ord  = '0;
    i_next = clr_r;
    i_prev = clr_r;
    if (pi < TOPB) begin
      if ((pi & (BS - 1)) == 0) begin
        i_head = 1'b1;
        i_ord  = OW'(TOP_ORDER);
        i_next = (pi == 0) ? PW'(TOPB - BS) : PW'(pi - BS);
        i_prev = (pi == TOPB - BS) ? '0 : PW'(pi + BS);
      end
    end else begin
      for (int o = 0; o < TOP_ORDER; o++) begin
        if ((((REM >> o) & 1) == 1) && ((pi - TOPB) == (REM & ~((2 << o) - 1)))) begin
          i_head = 1'b1;
          i_ord  = OW'(o);
        end
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.clear_last  = (int'(clr_r) == NUM_PAGES - 1);
    sts.req_free    = req_free_r;
    sts.dec_fail    = req_free_r ? addr_bad : alloc_fail;
    sts.head_free   = !info_q[OW];
    sts.split_more  = (ord_r > want_r);
    sts.split_valid = sbud_ok;
    sts.try_ok      = fbud_ok;
    sts.merge_ok    = !info_q[OW] && (info_q[OW-1:0] == ord_r);
    sts.push_empty  = !ne_r[pord_r];
    sts.out_busy    = out_valid_r && out_stall;
  end

  // Command execution
  always_comb begin
    req_free_nxt = req_free_r;
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    pg_nxt       = pg_r;
    u_nxt        = u_r;
    x_nxt        = x_r;
    h_nxt        = h_r;
    t_nxt        = t_r;
    clr_nxt      = clr_r;
    ord_nxt      = ord_r;
    want_nxt     = want_r;
    pord_nxt     = pord_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    head_nxt     = head_r;
    ne_nxt       = ne_r;
    out_st_nxt   = out_st_r;
    out_addr_nxt = out_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    info_we = 1'b0;
    info_wa = '0;
    info_wd = '0;
    info_ra = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    link_ra = '0;
    unique case (op)
      OP_NONE: ;
      // Sweep the memories to the initial tiling
      OP_CLEAR: begin
        info_we = 1'b1;
        info_wa = clr_r;
        info_wd = {!i_head, i_ord};
        next_we = 1'b1;
        next_wa = clr_r;
        next_wd = i_next;
        prev_we = 1'b1;
        prev_wa = clr_r;
        prev_wd = i_prev;
        clr_nxt = clr_r + PW'(1);
      end
      OP_LOAD: begin
        req_free_nxt = in_req_type;
        cnt_nxt      = in_req_pages;
        addr_nxt     = in_byte_addr;
      end
      OP_DECODE: begin
        res_st_nxt   = RES_OK;
        res_addr_nxt = '0;
        if (req_free_r) begin
          if (addr_bad) res_st_nxt = RES_ILLEGAL;
          info_ra = fpg;
          pg_nxt  = fpg;
        end else if (alloc_fail) begin
          res_st_nxt = RES_NOSPACE;
        end else begin
          want_nxt = OW'(want_i);
          ord_nxt  = OW'(found_i);
          pg_nxt   = head_r[OW'(found_i)];
          u_nxt    = head_r[OW'(found_i)];
        end
      end
      OP_UL_RD: link_ra = u_r;
      // Unlink u from list ord; advance the head if u was the head, or empty the list if u was its only entry
      OP_UL_WR: begin
        if (next_q == u_r) begin
          ne_nxt[ord_r]   = 1'b0;
          head_nxt[ord_r] = '0;
        end else begin
          next_we = 1'b1;
          next_wa = prev_q;
          next_wd = next_q;
          prev_we = 1'b1;
          prev_wa = next_q;
          prev_wd = prev_q;
          if (head_r[ord_r] == u_r) head_nxt[ord_r] = next_q;
        end
      end
      // Split one order down, or finish the allocate
      OP_SPLIT: begin
        if (ord_r > want_r) begin
          ord_nxt  = sord;
          x_nxt    = sbud;
          pord_nxt = sord;
          if (sbud_ok) begin
            info_we = 1'b1;
            info_wa = sbud;
            info_wd = {1'b0, sord};
          end
        end else begin
          info_we      = 1'b1;
          info_wa      = pg_r;
          info_wd      = {1'b1, want_r};
          res_st_nxt   = RES_OK;
          res_addr_nxt = ADDR_W'(32'(pg_r) << PS);
        end
      end
      // Push x onto the front of list pord
      OP_PUSH0: begin
        if (!ne_r[pord_r]) begin
          next_we = 1'b1;
          next_wa = x_r;
          next_wd = x_r;
          prev_we = 1'b1;
          prev_wa = x_r;
          prev_wd = x_r;
          head_nxt[pord_r] = x_r;
          ne_nxt[pord_r]   = 1'b1;
        end else begin
          link_ra = head_r[pord_r];
          h_nxt   = head_r[pord_r];
        end
      end
      OP_PUSH1: begin
        next_we = 1'b1;
        next_wa = x_r;
        next_wd = h_r;
        prev_we = 1'b1;
        prev_wa = x_r;
        prev_wd = prev_q;
        t_nxt   = prev_q;
      end
      OP_PUSH2: begin
        next_we = 1'b1;
        next_wa = t_r;
        next_wd = x_r;
        prev_we = 1'b1;
        prev_wa = h_r;
        prev_wd = x_r;
        head_nxt[pord_r] = x_r;
        ne_nxt[pord_r]   = 1'b1;
      end
      // Check the freed head and clear its busy flag
      OP_F_CHK: begin
        if (!info_q[OW]) begin
          res_st_nxt = RES_DOUBLE;
        end else begin
          info_we = 1'b1;
          info_wa = pg_r;
          info_wd = {1'b0, info_q[OW-1:0]};
          ord_nxt = info_q[OW-1:0];
        end
      end
      OP_F_TRY: begin
        info_ra  = fbud;
        u_nxt    = fbud;
        x_nxt    = pg_r;
        pord_nxt = ord_r;
      end
      OP_F_BCHK: begin
        x_nxt    = pg_r;
        pord_nxt = ord_r;
      end
      OP_F_HI: begin
        info_we = 1'b1;
        info_wa = hi_pg;
        info_wd = {1'b1, ord_r};
      end
      OP_F_LO: begin
        info_we = 1'b1;
        info_wa = lo_pg;
        info_wd = {1'b0, ord_r + OW'(1)};
        pg_nxt  = lo_pg;
        ord_nxt = ord_r + OW'(1);
      end
      // Hand the result to the output register once it is free
      OP_RESULT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
        end
      end
      default: ;
    endcase
  end

  // Page info memory
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_q <= info_mem[info_ra];
  end

  // Link memories
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_q <= prev_mem[link_ra];
  end

  // Control registers and list heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int o = 0; o < NL; o++) begin
        if (o == TOP_ORDER) begin
          ne_r[o]   <= (KTOP > 0);
          head_r[o] <= (KTOP > 0) ? PW'((KTOP - 1) * BS) : '0;
        end else begin
          ne_r[o]   <= (((REM >> o) & 1) == 1);
          head_r[o] <= (((REM >> o) & 1) == 1) ?
                       PW'(TOPB + (REM & ~((2 << o) - 1))) : '0;
        end
      end
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      ne_r        <= ne_nxt;
      head_r      <= head_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_free_r <= req_free_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    pg_r       <= pg_nxt;
    u_r        <= u_nxt;
    x_r        <= x_nxt;
    h_r        <= h_nxt;
    t_r        <= t_nxt;
    ord_r      <= ord_nxt;
    want_r     <= want_nxt;
    pord_r     <= pord_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_st_r;
  assign out_block_addr = out_addr_r;

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Buddy page allocator: one transaction at a time. An allocate decodes the request,
// unlinks the block it found and splits it one order at a time, pushing each split-off
// buddy onto its free list; a free checks the page, then merges with each free buddy
// and pushes the result onto its list. The next input is taken only after the result
// loads into the output register, later while the output side stalls. After reset a
// clearing pass tiles the pages before in_stall drops. Uses bpa_pkg, bpa_ctrl and bpa_dp.
module buddy_page_allocator #(
  parameter int NUM_PAGES  = 4096,
  parameter int TOP_ORDER  = 12,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [bpa_pkg::CNT_W-1:0]   in_req_pages,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_byte_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bpa_pkg::STS_W-1:0]   out_status,
  output logic [bpa_pkg::ADDR_W-1:0]  out_block_addr
);
  import bpa_pkg::*;

  bpa_op_t  op;
  bpa_sts_t sts;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  // Memories and working registers
  bpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .TOP_ORDER  (TOP_ORDER),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_req_pages   (in_req_pages),
    .in_byte_addr   (in_byte_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_block_addr (out_block_addr)
  );

endmodule
